[hdl/ines_pkg.sv]
// ----------------------------------------------------------------------------
// ines_pkg
// Shared types, codes and helpers for the cartridge image deframer.
// ----------------------------------------------------------------------------
package ines_pkg;

   localparam int unsigned PosWidth  = 23;
   localparam int unsigned HdrLen    = 16;
   localparam int unsigned PrgShift  = 14;   // 16 KB program banks
   localparam int unsigned ChrShift  = 12;   // 4 KB character banks

   localparam logic [7:0] MagicByte0 = 8'h4E;
   localparam logic [7:0] MagicByte1 = 8'h45;
   localparam logic [7:0] MagicByte2 = 8'h53;
   localparam logic [7:0] MagicByte3 = 8'h1A;

   typedef enum logic [1:0] {
      DEST_HEADER  = 2'd0,
      DEST_PRG     = 2'd1,
      DEST_CHR     = 2'd2,
      DEST_IGNORED = 2'd3
   } dest_type;

   typedef enum logic [1:0] {
      HDR_PENDING = 2'd0,
      HDR_VALID   = 2'd1,
      HDR_BAD     = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      MIRROR_HORIZONTAL = 2'd0,
      MIRROR_VERTICAL   = 2'd1,
      MIRROR_FOUR       = 2'd2
   } mirror_type;

   // One accepted byte plus the header snapshot it is decoded against.
   typedef struct packed {
      logic [7:0]          data_byte;
      logic                in_header;    // position below 16
      logic [3:0]          hdr_offset;
      logic                hdr_done;     // position 15 or later
      logic                magic_bad;
      logic                tail_dirty;
      logic [7:0]          hdr_byte4;
      logic [7:0]          hdr_byte5;
      logic [7:0]          hdr_byte6;
      logic [7:0]          hdr_byte7;
      logic [PosWidth-1:0] data_pos;     // position minus header length
   } stage_type;

   typedef struct packed {
      dest_type   destination;
      logic [8:0] bank_index;
      logic [13:0] byte_offset;
      logic [7:0] byte_value;
      status_type header_status;
      logic [7:0] prg_banks;
      logic [8:0] chr_banks_4k;
      mirror_type mirror;
      logic       has_battery;
      logic       has_trainer;
      logic [7:0] mapper_number;
      logic       mapper_supported;
   } result_type;

   function automatic logic mapper_is_supported(input logic [7:0] m);
      logic sup;
      begin
         unique case (m)
            8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd7, 8'd9, 8'd11, 8'd18: sup = 1'b1;
            default: sup = 1'b0;
         endcase
         return sup;
      end
   endfunction

endpackage

[hdl/ines_image_deframer.sv]
// ----------------------------------------------------------------------------
// ines_image_deframer
// Cartridge image deframer: header capture and decode, PRG/CHR byte routing.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries the image one byte per transfer; req_tlast marks the final
//   byte, after which position and header state reset for the next image.
//   rsp_* returns one result per byte: its destination (header, program ROM,
//   character ROM or ignored) in rsp_tuser, and bank, offset, the byte and the
//   decoded header fields in rsp_tdata.
//   Each accepted byte is registered after the position counter and header
//   capture, then after the decode and bank/offset routing. Throughput is
//   one byte per cycle while rsp_tready is high. A stalled receiver holds
//   the result register; the stage register behind it takes one more byte
//   only if empty, then req_tready drops until rsp_tready returns. Reset
//   clears the position counter, the captured header bytes, the magic and
//   tail flags and both valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ines_image_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // end_of_image
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [8:0] bank_index, [22:9] byte_offset, [30:23] byte_value,
   // [32:31] header_status, [40:33] prg_banks, [49:41] chr_banks_4k,
   // [51:50] mirror_type, [52] has_battery, [53] has_trainer,
   // [61:54] mapper_number, [62] mapper_supported, [63] zero
   output logic [63:0] rsp_tdata,
   output logic [1:0]  rsp_tuser    // [1:0] destination
);
   import ines_pkg::*;

   logic       stage_valid;
   logic       stage_ready;
   stage_type  stage;
   result_type rsp;

   ines_tracker u_tracker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .stage_ready (stage_ready),
      .stage_valid (stage_valid),
      .stage       (stage)
   );

   ines_router u_router (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid),
      .stage_ready (stage_ready),
      .stage       (stage),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp         (rsp)
   );

   assign rsp_tuser = rsp.destination;
   assign rsp_tdata = {1'b0,
                       rsp.mapper_supported,
                       rsp.mapper_number,
                       rsp.has_trainer,
                       rsp.has_battery,
                       rsp.mirror,
                       rsp.chr_banks_4k,
                       rsp.prg_banks,
                       rsp.header_status,
                       rsp.byte_value,
                       rsp.byte_offset,
                       rsp.bank_index};

endmodule

[hdl/ines_tracker.sv]
// ----------------------------------------------------------------------------
// ines_tracker
// Byte position counter and header capture; registers each accepted byte
// together with the header snapshot it needs downstream.
// ----------------------------------------------------------------------------
module ines_tracker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,
   input  logic                req_tlast,
   input  logic                stage_ready,
   output logic                stage_valid,
   output ines_pkg::stage_type stage
);
   import ines_pkg::*;

   localparam logic [PosWidth-1:0] PosMax = {PosWidth{1'b1}};
   localparam logic [PosWidth-1:0] HdrLenPos = PosWidth'(HdrLen);

   logic [PosWidth-1:0] pos_ff, pos_in;
   logic                magic_bad_ff, magic_bad_in;
   logic                tail_dirty_ff, tail_dirty_in;
   logic [7:0]          hdr4_ff, hdr4_in, hdr5_ff, hdr5_in;
   logic [7:0]          hdr6_ff, hdr6_in, hdr7_ff, hdr7_in;
   logic                stage_valid_ff, stage_valid_in;
   stage_type           stage_ff, stage_in;

   logic       accept;
   logic       in_header;
   logic [7:0] magic_expect;

   assign req_tready = !stage_valid_ff || stage_ready;
   assign accept     = req_tvalid && req_tready;
   assign in_header  = (pos_ff[PosWidth-1:4] == '0);

   always_comb begin
      unique case (pos_ff[1:0])
         2'd0:    magic_expect = MagicByte0;
         2'd1:    magic_expect = MagicByte1;
         2'd2:    magic_expect = MagicByte2;
         default: magic_expect = MagicByte3;
      endcase
   end

   always_comb begin
      magic_bad_in  = magic_bad_ff;
      tail_dirty_in = tail_dirty_ff;
      hdr4_in = hdr4_ff;
      hdr5_in = hdr5_ff;
      hdr6_in = hdr6_ff;
      hdr7_in = hdr7_ff;
      if (in_header && pos_ff[3:2] == 2'd0 && req_tdata != magic_expect) begin
         magic_bad_in = 1'b1;
      end
      if (in_header && pos_ff[3] && req_tdata != 8'd0) begin
         tail_dirty_in = 1'b1;
      end
      if (in_header && pos_ff[3:0] == 4'd4) hdr4_in = req_tdata;
      if (in_header && pos_ff[3:0] == 4'd5) hdr5_in = req_tdata;
      if (in_header && pos_ff[3:0] == 4'd6) hdr6_in = req_tdata;
      if (in_header && pos_ff[3:0] == 4'd7) hdr7_in = req_tdata;

      stage_in.data_byte  = req_tdata;
      stage_in.in_header  = in_header;
      stage_in.hdr_offset = pos_ff[3:0];
      stage_in.hdr_done   = !in_header || pos_ff[3:0] == 4'hF;
      stage_in.magic_bad  = magic_bad_in;
      stage_in.tail_dirty = tail_dirty_in;
      stage_in.hdr_byte4  = hdr4_in;
      stage_in.hdr_byte5  = hdr5_in;
      stage_in.hdr_byte6  = hdr6_in;
      stage_in.hdr_byte7  = hdr7_in;
      stage_in.data_pos   = pos_ff - HdrLenPos;

      if (pos_ff == PosMax) pos_in = pos_ff;
      else                  pos_in = pos_ff + 1'b1;

      stage_valid_in = accept ? 1'b1 : (stage_ready ? 1'b0 : stage_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         magic_bad_ff   <= 1'b0;
         tail_dirty_ff  <= 1'b0;
         hdr4_ff        <= '0;
         hdr5_ff        <= '0;
         hdr6_ff        <= '0;
         hdr7_ff        <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         if (accept) begin
            if (req_tlast) begin
               // end of image: back to the post-reset state
               pos_ff        <= '0;
               magic_bad_ff  <= 1'b0;
               tail_dirty_ff <= 1'b0;
               hdr4_ff       <= '0;
               hdr5_ff       <= '0;
               hdr6_ff       <= '0;
               hdr7_ff       <= '0;
            end else begin
               pos_ff        <= pos_in;
               magic_bad_ff  <= magic_bad_in;
               tail_dirty_ff <= tail_dirty_in;
               hdr4_ff       <= hdr4_in;
               hdr5_ff       <= hdr5_in;
               hdr6_ff       <= hdr6_in;
               hdr7_ff       <= hdr7_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_valid = stage_valid_ff;
   assign stage       = stage_ff;

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> pos_ff == '0 && !magic_bad_ff && !tail_dirty_ff)
      else $error("state not cleared after end of image");

   a_pos_steps: assert property (@(posedge clock) disable iff (reset)
      accept && !req_tlast && pos_ff != PosMax |=> pos_ff == $past(pos_ff) + 1'b1)
      else $error("position counter did not advance");

   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && !stage_ready |-> !accept)
      else $error("accepted while stage register blocked");

endmodule

[hdl/ines_router.sv]
// ----------------------------------------------------------------------------
// ines_router
// Header field decode and PRG/CHR routing into the result register.
// ----------------------------------------------------------------------------
module ines_router (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 stage_valid,
   output logic                 stage_ready,
   input  ines_pkg::stage_type  stage,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ines_pkg::result_type rsp
);
   import ines_pkg::*;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;

   logic       take;
   logic       decoded;
   logic [7:0] mapper_raw;
   logic [8:0] prg_hi;      // data position in 16 KB units
   logic [8:0] chr_hi;      // 16 KB units left after program ROM
   logic [10:0] chr_units;  // 4 KB units left after program ROM
   logic [8:0] chr_count;

   assign stage_ready = !rsp_valid_ff || rsp_ready;
   assign take        = stage_valid && stage_ready;

   always_comb begin
      decoded    = stage.hdr_done && !stage.magic_bad;
      mapper_raw = {stage.hdr_byte7[7:4], stage.hdr_byte6[7:4]};
      if (stage.tail_dirty) mapper_raw = {4'd0, stage.hdr_byte6[7:4]};
      chr_count  = {stage.hdr_byte5, 1'b0};

      prg_hi    = stage.data_pos[PosWidth-1:PrgShift];
      chr_hi    = prg_hi - {1'b0, stage.hdr_byte4};
      chr_units = {chr_hi, stage.data_pos[PrgShift-1:ChrShift]};

      rsp_in = '0;
      rsp_in.destination   = DEST_IGNORED;
      rsp_in.byte_value    = stage.data_byte;
      rsp_in.header_status = HDR_PENDING;

      if (stage.hdr_done) begin
         rsp_in.header_status = stage.magic_bad ? HDR_BAD : HDR_VALID;
      end
      if (decoded) begin
         rsp_in.prg_banks        = stage.hdr_byte4;
         rsp_in.chr_banks_4k     = chr_count;
         priority if (stage.hdr_byte6[3]) rsp_in.mirror = MIRROR_FOUR;
         else if (stage.hdr_byte6[0])     rsp_in.mirror = MIRROR_VERTICAL;
         else                             rsp_in.mirror = MIRROR_HORIZONTAL;
         rsp_in.has_battery      = stage.hdr_byte6[1];
         rsp_in.has_trainer      = stage.hdr_byte6[2];
         rsp_in.mapper_number    = mapper_raw;
         rsp_in.mapper_supported = mapper_is_supported(mapper_raw);
      end

      if (stage.in_header) begin
         rsp_in.destination = DEST_HEADER;
         rsp_in.byte_offset = {10'd0, stage.hdr_offset};
      end else if (!stage.magic_bad) begin
         if (prg_hi < {1'b0, stage.hdr_byte4}) begin
            rsp_in.destination = DEST_PRG;
            rsp_in.bank_index  = prg_hi;
            rsp_in.byte_offset = stage.data_pos[PrgShift-1:0];
         end else if (chr_units < {2'd0, chr_count}) begin
            rsp_in.destination = DEST_CHR;
            rsp_in.bank_index  = chr_units[8:0];
            rsp_in.byte_offset = {2'd0, stage.data_pos[ChrShift-1:0]};
         end
      end

      rsp_valid_in = take ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   a_rom_needs_valid_hdr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.destination == DEST_PRG || rsp_ff.destination == DEST_CHR)
      |-> rsp_ff.header_status == HDR_VALID)
      else $error("ROM byte routed without a valid header");

   a_fields_zero_unless_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.header_status != HDR_VALID
      |-> rsp_ff.mapper_number == 8'd0 && !rsp_ff.mapper_supported
          && rsp_ff.prg_banks == 8'd0)
      else $error("decoded fields set without a valid header");

   a_header_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.destination == DEST_HEADER
      |-> rsp_ff.bank_index == 9'd0 && rsp_ff.byte_offset[13:4] == 10'd0)
      else $error("header byte with bank or offset out of range");

endmodule
